[hw/rtl/qvr_pkg.sv]
// Package with shared widths and types for the quaternion vector rotation pipeline.
package qvr_pkg;

	localparam int DATA_W = 16;
	localparam int NUM_W = 52;
	localparam int DVS_W = 34;
	localparam int QUOT_W = 16;
	localparam int FRONT_STAGES = 5;
	localparam int DIV_STAGES = 8;
	localparam int BITS_PER_STAGE = QUOT_W / DIV_STAGES;
	localparam int LANE_STAGES = DIV_STAGES + 1;
	localparam int PIPE_STAGES = FRONT_STAGES + LANE_STAGES;

	typedef struct packed {
		logic [NUM_W-1:0] num;
		logic [DVS_W-1:0] dvs;
		logic             neg;
	} qvr_div_in_t;

endpackage

[hw/rtl/qvr_front.sv]
// Front pipeline: products, sums and the rounded dividend and divisor per component.
module qvr_front import qvr_pkg::*; (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [DATA_W-1:0] qw,
	input  logic signed [DATA_W-1:0] qx,
	input  logic signed [DATA_W-1:0] qy,
	input  logic signed [DATA_W-1:0] qz,
	input  logic signed [DATA_W-1:0] vx,
	input  logic signed [DATA_W-1:0] vy,
	input  logic signed [DATA_W-1:0] vz,
	output qvr_div_in_t              div_x,
	output qvr_div_in_t              div_y,
	output qvr_div_in_t              div_z,
	output logic                     zero
);

	logic signed [31:0] ww_s1, xx_s1, yy_s1, zz_s1;
	logic signed [31:0] xvx_s1, yvy_s1, zvz_s1;
	logic signed [31:0] yvz_s1, zvy_s1, zvx_s1, xvz_s1, xvy_s1, yvx_s1;
	logic signed [DATA_W-1:0] w_s1, x_s1, y_s1, z_s1, vx_s1, vy_s1, vz_s1;

	logic [32:0] den_s2;
	logic signed [33:0] s_s2;
	logic signed [34:0] d2_s2;
	logic signed [32:0] cx_s2, cy_s2, cz_s2;
	logic signed [DATA_W-1:0] w_s2, x_s2, y_s2, z_s2, vx_s2, vy_s2, vz_s2;
	logic zero_s2;
	logic signed [34:0] den_c, uu_c;

	logic signed [51:0] a_x_s3, a_y_s3, a_z_s3;
	logic signed [51:0] b_x_s3, b_y_s3, b_z_s3;
	logic signed [51:0] c_x_s3, c_y_s3, c_z_s3;
	logic [32:0] den_s3;
	logic zero_s3;

	logic signed [51:0] n_x_s4, n_y_s4, n_z_s4;
	logic [32:0] den_s4;
	logic zero_s4;

	qvr_div_in_t div_x_s5, div_y_s5, div_z_s5;
	logic zero_s5;

	function automatic qvr_div_in_t make_div(input logic signed [51:0] n,
		input logic [32:0] den);
		qvr_div_in_t r;
		logic [NUM_W-1:0] mag;
		mag = n[51] ? NUM_W'(-n) : NUM_W'(n);
		r.neg = n[51];
		r.num = (mag << 1) + NUM_W'(den);
		r.dvs = {den, 1'b0};
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			ww_s1 <= qw * qw;
			xx_s1 <= qx * qx;
			yy_s1 <= qy * qy;
			zz_s1 <= qz * qz;
			xvx_s1 <= qx * vx;
			yvy_s1 <= qy * vy;
			zvz_s1 <= qz * vz;
			yvz_s1 <= qy * vz;
			zvy_s1 <= qz * vy;
			zvx_s1 <= qz * vx;
			xvz_s1 <= qx * vz;
			xvy_s1 <= qx * vy;
			yvx_s1 <= qy * vx;
			w_s1 <= qw;
			x_s1 <= qx;
			y_s1 <= qy;
			z_s1 <= qz;
			vx_s1 <= vx;
			vy_s1 <= vy;
			vz_s1 <= vz;
		end
	end

	assign uu_c = 35'(xx_s1) + 35'(yy_s1) + 35'(zz_s1);
	assign den_c = 35'(ww_s1) + uu_c;

	always_ff @(posedge clk) begin
		if (en) begin
			den_s2 <= den_c[32:0];
			zero_s2 <= (den_c == '0);
			s_s2 <= 34'(35'(ww_s1) - uu_c);
			d2_s2 <= (35'(xvx_s1) + 35'(yvy_s1) + 35'(zvz_s1)) <<< 1;
			cx_s2 <= 33'(yvz_s1) - 33'(zvy_s1);
			cy_s2 <= 33'(zvx_s1) - 33'(xvz_s1);
			cz_s2 <= 33'(xvy_s1) - 33'(yvx_s1);
			w_s2 <= w_s1;
			x_s2 <= x_s1;
			y_s2 <= y_s1;
			z_s2 <= z_s1;
			vx_s2 <= vx_s1;
			vy_s2 <= vy_s1;
			vz_s2 <= vz_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_x_s3 <= 52'(s_s2) * 52'(vx_s2);
			a_y_s3 <= 52'(s_s2) * 52'(vy_s2);
			a_z_s3 <= 52'(s_s2) * 52'(vz_s2);
			b_x_s3 <= 52'(d2_s2) * 52'(x_s2);
			b_y_s3 <= 52'(d2_s2) * 52'(y_s2);
			b_z_s3 <= 52'(d2_s2) * 52'(z_s2);
			c_x_s3 <= 52'(w_s2) * 52'(cx_s2);
			c_y_s3 <= 52'(w_s2) * 52'(cy_s2);
			c_z_s3 <= 52'(w_s2) * 52'(cz_s2);
			den_s3 <= den_s2;
			zero_s3 <= zero_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_x_s4 <= a_x_s3 + b_x_s3 + (c_x_s3 <<< 1);
			n_y_s4 <= a_y_s3 + b_y_s3 + (c_y_s3 <<< 1);
			n_z_s4 <= a_z_s3 + b_z_s3 + (c_z_s3 <<< 1);
			den_s4 <= den_s3;
			zero_s4 <= zero_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_x_s5 <= make_div(n_x_s4, den_s4);
			div_y_s5 <= make_div(n_y_s4, den_s4);
			div_z_s5 <= make_div(n_z_s4, den_s4);
			zero_s5 <= zero_s4;
		end
	end

	assign div_x = div_x_s5;
	assign div_y = div_y_s5;
	assign div_z = div_z_s5;
	assign zero = zero_s5;

endmodule

[hw/rtl/qvr_div_lane.sv]
// Pipelined restoring divider lane with rounding and 16-bit saturation.
module qvr_div_lane import qvr_pkg::*; (
	input  logic                     clk,
	input  logic                     en,
	input  qvr_div_in_t              din,
	output logic signed [DATA_W-1:0] res,
	output logic                     sat
);

	logic [NUM_W-1:0]  rem_s [0:DIV_STAGES];
	logic [QUOT_W-1:0] quo_s [0:DIV_STAGES];
	logic [DVS_W-1:0]  dvs_s [0:DIV_STAGES];
	logic              neg_s [0:DIV_STAGES];
	logic              ovf_s [0:DIV_STAGES];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= din.num;
			dvs_s[0] <= din.dvs;
			neg_s[0] <= din.neg;
			ovf_s[0] <= din.num >= (NUM_W'(din.dvs) << QUOT_W);
			quo_s[0] <= '0;
		end
	end

	for (genvar j = 1; j <= DIV_STAGES; j++) begin : g_stage
		logic [NUM_W-1:0]  rem_c;
		logic [QUOT_W-1:0] quo_c;

		always_comb begin
			rem_c = rem_s[j-1];
			quo_c = quo_s[j-1];
			for (int b = 0; b < BITS_PER_STAGE; b++) begin
				if (rem_c >= (NUM_W'(dvs_s[j-1]) << (QUOT_W - BITS_PER_STAGE * (j - 1) - 1 - b))) begin
					rem_c = rem_c -
						(NUM_W'(dvs_s[j-1]) << (QUOT_W - BITS_PER_STAGE * (j - 1) - 1 - b));
					quo_c[QUOT_W - BITS_PER_STAGE * (j - 1) - 1 - b] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j] <= rem_c;
				quo_s[j] <= quo_c;
				dvs_s[j] <= dvs_s[j-1];
				neg_s[j] <= neg_s[j-1];
				ovf_s[j] <= ovf_s[j-1];
			end
		end
	end

	always_comb begin
		if (neg_s[DIV_STAGES]) begin
			if (ovf_s[DIV_STAGES] || quo_s[DIV_STAGES] > 16'd32768) begin
				res = 16'sh8000;
				sat = 1'b1;
			end else begin
				res = DATA_W'(16'd0 - quo_s[DIV_STAGES]);
				sat = 1'b0;
			end
		end else begin
			if (ovf_s[DIV_STAGES] || quo_s[DIV_STAGES] > 16'd32767) begin
				res = 16'sh7fff;
				sat = 1'b1;
			end else begin
				res = DATA_W'(quo_s[DIV_STAGES]);
				sat = 1'b0;
			end
		end
	end

endmodule

[hw/rtl/quaternion_vector_rotation.sv]
// Top level of the quaternion vector rotation pipeline.
//
// The input channel (in_valid, in_stall) carries one beat per item: a quaternion
// quat_w..quat_z and a vector vec_x..vec_z, all signed Q3.12. The output channel
// (out_valid, out_stall) returns one beat per item: the rotated vector rot_x..rot_z,
// a saturated flag and a zero_norm flag.
// From an accepted input beat to its output beat, the data passes five front stages
// of products and sums, nine stages of the divider lanes (an entry stage and eight
// stages of two quotient bits each), and the output register.
// Throughput is one beat per cycle while out_stall does not hold the output beat.
// The whole pipeline advances together; while the output beat is held by
// out_stall, in_stall is raised and every stage keeps its contents.
// Reset clears all valid bits, so the pipeline comes up empty.
// A zero quaternion gives a zero vector with zero_norm set.
module quaternion_vector_rotation import qvr_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [DATA_W-1:0] quat_w,
	input  logic signed [DATA_W-1:0] quat_x,
	input  logic signed [DATA_W-1:0] quat_y,
	input  logic signed [DATA_W-1:0] quat_z,
	input  logic signed [DATA_W-1:0] vec_x,
	input  logic signed [DATA_W-1:0] vec_y,
	input  logic signed [DATA_W-1:0] vec_z,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] rot_x,
	output logic signed [DATA_W-1:0] rot_y,
	output logic signed [DATA_W-1:0] rot_z,
	output logic                     saturated,
	output logic                     zero_norm
);

	logic en;
	logic vld_s [0:PIPE_STAGES-1];
	logic zero_s [0:LANE_STAGES-1];
	qvr_div_in_t div_x, div_y, div_z;
	logic front_zero;
	logic signed [DATA_W-1:0] res_x, res_y, res_z;
	logic sat_x, sat_y, sat_z;
	logic valid_q;
	logic signed [DATA_W-1:0] rot_x_q, rot_y_q, rot_z_q;
	logic sat_q, zero_q;

	assign en = !(valid_q && out_stall);
	assign in_stall = !en;

	qvr_front u_front (
		.clk   (clk),
		.en    (en),
		.qw    (quat_w),
		.qx    (quat_x),
		.qy    (quat_y),
		.qz    (quat_z),
		.vx    (vec_x),
		.vy    (vec_y),
		.vz    (vec_z),
		.div_x (div_x),
		.div_y (div_y),
		.div_z (div_z),
		.zero  (front_zero)
	);

	qvr_div_lane u_lane_x (.clk(clk), .en(en), .din(div_x), .res(res_x), .sat(sat_x));
	qvr_div_lane u_lane_y (.clk(clk), .en(en), .din(div_y), .res(res_y), .sat(sat_y));
	qvr_div_lane u_lane_z (.clk(clk), .en(en), .din(div_z), .res(res_z), .sat(sat_z));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PIPE_STAGES; i++) begin
				vld_s[i] <= 1'b0;
			end
			valid_q <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int i = 1; i < PIPE_STAGES; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
			valid_q <= vld_s[PIPE_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= front_zero;
			for (int i = 1; i < LANE_STAGES; i++) begin
				zero_s[i] <= zero_s[i-1];
			end
			if (zero_s[LANE_STAGES-1]) begin
				rot_x_q <= '0;
				rot_y_q <= '0;
				rot_z_q <= '0;
				sat_q <= 1'b0;
			end else begin
				rot_x_q <= res_x;
				rot_y_q <= res_y;
				rot_z_q <= res_z;
				sat_q <= sat_x || sat_y || sat_z;
			end
			zero_q <= zero_s[LANE_STAGES-1];
		end
	end

	assign out_valid = valid_q;
	assign rot_x = rot_x_q;
	assign rot_y = rot_y_q;
	assign rot_z = rot_z_q;
	assign saturated = sat_q;
	assign zero_norm = zero_q;

`ifndef SYNTHESIS
	a_zero_clean: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && zero_q |-> rot_x_q == 0 && rot_y_q == 0 && rot_z_q == 0 && !sat_q)
		else $error("zero_norm beat with nonzero payload");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && out_stall |=> valid_q)
		else $error("output beat dropped during stall");
	a_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_q) |-> $past(vld_s[PIPE_STAGES-1]))
		else $error("output valid without a beat in the last stage");
`endif

endmodule

[tb/tb_quaternion_vector_rotation.sv]
// Testbench for the quaternion vector rotation pipeline with a built-in predictor.
`timescale 1ns / 100ps

module tb_quaternion_vector_rotation;
	import qvr_pkg::*;

	typedef struct {
		logic signed [DATA_W-1:0] w, x, y, z, vx, vy, vz;
	} rot_req_t;

	typedef struct {
		logic signed [DATA_W-1:0] rx, ry, rz;
		logic sat;
		logic zn;
	} rot_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [DATA_W-1:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
	logic signed [DATA_W-1:0] vec_x = '0, vec_y = '0, vec_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [DATA_W-1:0] rot_x, rot_y, rot_z;
	logic saturated, zero_norm;

	rot_req_t pending_q[$];
	rot_res_t rotated_q[$];
	int errors = 0;
	bit feeding_done = 0;
	int unsigned cycles = 0;
	bit in_accepted = 0;

	quaternion_vector_rotation u_top (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Rounded quotient with ties away from zero, clamped to 16 bits.
	function automatic logic signed [DATA_W-1:0] div_round(longint n, longint d, ref logic sat);
		longint mag;
		longint q;
		mag = (n < 0) ? -n : n;
		q = (mag * 2 + d) / (d * 2);
		if (n < 0) begin
			if (q > 32768) begin
				sat = 1'b1;
				return -16'sd32768;
			end
			return DATA_W'(-q);
		end
		if (q > 32767) begin
			sat = 1'b1;
			return 16'sd32767;
		end
		return DATA_W'(q);
	endfunction

	function automatic rot_res_t rotate_vector(rot_req_t r);
		rot_res_t o;
		longint w, x, y, z, vx, vy, vz, uu, den, s, d2, cx, cy, cz;
		logic sat;
		w = r.w; x = r.x; y = r.y; z = r.z; vx = r.vx; vy = r.vy; vz = r.vz;
		uu = x*x + y*y + z*z;
		den = w*w + uu;
		sat = 1'b0;
		if (den == 0) begin
			o.rx = '0; o.ry = '0; o.rz = '0; o.sat = 1'b0; o.zn = 1'b1;
			return o;
		end
		s = w*w - uu;
		d2 = 2 * (x*vx + y*vy + z*vz);
		cx = y*vz - z*vy;
		cy = z*vx - x*vz;
		cz = x*vy - y*vx;
		o.rx = div_round(s*vx + d2*x + 2*w*cx, den, sat);
		o.ry = div_round(s*vy + d2*y + 2*w*cy, den, sat);
		o.rz = div_round(s*vz + d2*z + 2*w*cz, den, sat);
		o.sat = sat;
		o.zn = 1'b0;
		return o;
	endfunction

	function automatic logic signed [DATA_W-1:0] rand_field(int mode);
		case (mode)
			0: return DATA_W'($urandom);
			1: return DATA_W'($urandom_range(0, 8192) - 4096);
			2: return DATA_W'($urandom_range(0, 64) - 32);
			default: return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
		endcase
	endfunction

	task automatic add_item(int qw, int qx, int qy, int qz, int ax, int ay, int az);
		rot_req_t r;
		r.w = DATA_W'(qw); r.x = DATA_W'(qx); r.y = DATA_W'(qy); r.z = DATA_W'(qz);
		r.vx = DATA_W'(ax); r.vy = DATA_W'(ay); r.vz = DATA_W'(az);
		pending_q.push_back(r);
	endtask

	// Driver: bursts of beats separated by random gaps.
	int burst_left = 0;
	int gap_left = 0;
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_accepted)) begin
			if (in_valid)
				void'(pending_q.pop_front());
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (pending_q.size() > 0) begin
				quat_w <= pending_q[0].w; quat_x <= pending_q[0].x;
				quat_y <= pending_q[0].y; quat_z <= pending_q[0].z;
				vec_x <= pending_q[0].vx; vec_y <= pending_q[0].vy;
				vec_z <= pending_q[0].vz;
				in_valid <= 1'b1;
				if (burst_left <= 0) begin
					burst_left <= $urandom_range(1, 40);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
				end else
					burst_left <= burst_left - 1;
			end else begin
				in_valid <= 1'b0;
				if (feeding_done == 0 && cycles > 20)
					feeding_done = 1;
			end
		end
	end

	// Receiver stall pattern, with one long hold-off.
	int hold_count = 0;
	always @(negedge clk) begin
		if (cycles == 400)
			hold_count <= 200;
		else if (hold_count > 0)
			hold_count <= hold_count - 1;
		if (hold_count > 0)
			out_stall <= 1'b1;
		else begin
			case ((cycles / 500) % 3)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				default: out_stall <= ($urandom_range(0, 1) == 0);
			endcase
		end
	end

	// Predict on accepted input beats, check on accepted output beats.
	always @(posedge clk) begin
		rot_res_t e;
		rot_req_t r;
		cycles <= cycles + 1;
		in_accepted <= arst_n && in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall) begin
			r.w = quat_w; r.x = quat_x; r.y = quat_y; r.z = quat_z;
			r.vx = vec_x; r.vy = vec_y; r.vz = vec_z;
			rotated_q.push_back(rotate_vector(r));
		end
		if (arst_n && out_valid && !out_stall) begin
			if (rotated_q.size() == 0) begin
				$error("unexpected output beat");
				errors++;
			end else begin
				e = rotated_q.pop_front();
				if (rot_x !== e.rx) begin
					$error("rot_x expected %0d actual %0d", e.rx, rot_x); errors++;
				end
				if (rot_y !== e.ry) begin
					$error("rot_y expected %0d actual %0d", e.ry, rot_y); errors++;
				end
				if (rot_z !== e.rz) begin
					$error("rot_z expected %0d actual %0d", e.rz, rot_z); errors++;
				end
				if (saturated !== e.sat) begin
					$error("saturated expected %0b actual %0b", e.sat, saturated); errors++;
				end
				if (zero_norm !== e.zn) begin
					$error("zero_norm expected %0b actual %0b", e.zn, zero_norm); errors++;
				end
			end
		end
	end

	initial begin
		int mode;
		// Directed beats: identity, zero quaternion, extremes, saturation, rounding.
		add_item(4096, 0, 0, 0, 4096, -4096, 1234);
		add_item(0, 0, 0, 0, 100, 200, 300);
		add_item(0, 0, 0, 0, 32767, -32768, 0);
		add_item(0, 4096, 0, 0, 4096, 4096, 4096);
		add_item(2896, 0, 0, 2896, 4096, 0, 0);
		add_item(32767, 32767, 32767, 32767, 32767, 32767, 32767);
		add_item(-32768, -32768, -32768, -32768, -32768, -32768, -32768);
		add_item(-32768, 0, 0, 0, -32768, 32767, -1);
		add_item(1, 1, 0, 0, 32767, 32767, 32767);
		add_item(1, 1, 1, 1, -32768, -32768, -32768);
		add_item(0, 0, 0, 1, 32767, -32768, 5);
		add_item(0, 0, 0, -32768, -1, 1, 32767);
		add_item(3, 0, 0, 1, 1, 1, 0);
		add_item(1, 2, 3, 4, 5, 6, 7);
		add_item(-1, 0, 0, 0, -1, -1, -1);
		add_item(100, -50, 25, 75, 32767, 0, -32768);
		for (int i = 0; i < 1150; i++) begin
			mode = $urandom_range(0, 9);
			add_item(rand_field(mode % 4), rand_field(mode % 4), rand_field((mode + 1) % 4),
				rand_field(mode % 3), rand_field(0), rand_field(mode % 2), rand_field(0));
		end
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		wait (feeding_done && rotated_q.size() == 0);
		repeat (30) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		wait (cycles > 200000);
		$display("status: fail");
		$finish;
	end

endmodule
